>>> rtl/rtt_pkg.sv
// Shared types, constants and helpers for the retransmit tracker.
// Used by every module of the block; depends on nothing else.
package rtt_pkg;

  localparam int RING_DEPTH  = 8;
  localparam int MAX_PAYLOAD = 1400;
  localparam int IDX_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = $clog2(RING_DEPTH + 1);
  localparam int LEN_W       = 11;
  localparam int TMO_W       = 16;
  localparam int RTY_W       = 4;

  localparam logic [TMO_W-1:0] INIT_TMO_RST  = 16'd1000;
  localparam logic [TMO_W-1:0] MAX_TMO_RST   = 16'd8000;
  localparam logic [RTY_W-1:0] RETRY_LIM_RST = 4'd5;

  localparam logic [1:0] CFG_INIT_TMO  = 2'd0;
  localparam logic [1:0] CFG_MAX_TMO   = 2'd1;
  localparam logic [1:0] CFG_RETRY_LIM = 2'd2;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_SYN_BIT = 1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_PUSHED     = 3'd0,
    KIND_RING_FULL  = 3'd1,
    KIND_RETRANSMIT = 3'd2,
    KIND_GAVE_UP    = 3'd3,
    KIND_TICK_DONE  = 3'd4,
    KIND_DONE       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ALU_AHEAD  = 2'd0,
    ALU_COVER  = 2'd1,
    ALU_EXPIRE = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic [31:0]      seq;
    logic [31:0]      end_seq;
    logic [LEN_W-1:0] len;
    logic [7:0]       flags;
    logic [31:0]      sent;
    logic [TMO_W-1:0] tmo;
    logic [RTY_W-1:0] retries;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ring_wr_t;

  typedef struct packed {
    alu_op_t          op;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [TMO_W-1:0] lim;
  } alu_req_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [IDX_W-1:0] slot;
    logic [31:0]      seq;
    logic [7:0]       flags;
    logic [LEN_W-1:0] len;
    logic [RTY_W-1:0] retries;
    logic [CNT_W-1:0] occupancy;
    logic             last;
  } result_t;

  // Ring index arithmetic; the offset never exceeds the depth.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W+1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // SYN and FIN each take one sequence number.
  function automatic logic [1:0] flag_extra(input logic [7:0] flags);
    return {1'b0, flags[FLAG_SYN_BIT]} + {1'b0, flags[FLAG_FIN_BIT]};
  endfunction

endpackage

>>> rtl/rtt_alu.sv
// Shared 32-bit wrap-safe subtract and compare unit of the tracker.
// Depends on rtt_pkg for the request type and operation codes.
module rtt_alu (
  input  rtt_pkg::alu_req_t req,
  output logic              hit
);
  import rtt_pkg::*;

  logic [31:0] diff;

  assign diff = req.a - req.b;

  always_comb begin
    case (req.op)
      ALU_AHEAD:  hit = (diff != 32'd0) && !diff[31];
      ALU_COVER:  hit = !diff[31];
      ALU_EXPIRE: hit = diff >= {16'd0, req.lim};
      default:    hit = 1'b0;
    endcase
  end

endmodule

>>> rtl/rtt_ring.sv
// Descriptor memory of the tracker: one write port, one registered read port.
// Depends on rtt_pkg for the entry and write request types.
module rtt_ring (
  input  logic                         clk,
  input  rtt_pkg::ring_wr_t            wr,
  input  logic [rtt_pkg::IDX_W-1:0]    raddr,
  output rtt_pkg::entry_t              rdata
);
  import rtt_pkg::*;

  entry_t mem [RING_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rtt_ctrl.sv
// Sequencer of the tracker: ring pointers, ack mark, configuration and result register.
// Depends on rtt_pkg; drives rtt_ring and rtt_alu.
module rtt_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_seq_value,
  input  logic [rtt_pkg::LEN_W-1:0]    in_payload_len,
  input  logic [7:0]                   in_seg_flags,
  input  logic [31:0]                  in_now_ms,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  output rtt_pkg::ring_wr_t            ring_wr,
  output logic [rtt_pkg::IDX_W-1:0]    ring_raddr,
  input  rtt_pkg::entry_t              ring_rdata,
  output rtt_pkg::alu_req_t            alu_req,
  input  logic                         alu_hit,
  output rtt_pkg::result_t             result
);
  import rtt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ACK_CMP = 9'b000000010,
    S_ACK_RD  = 9'b000000100,
    S_ACK_EV  = 9'b000001000,
    S_P1_RD   = 9'b000010000,
    S_P1_EV   = 9'b000100000,
    S_P2_RD   = 9'b001000000,
    S_P2_EV   = 9'b010000000,
    S_TDONE   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      mark_r, mark_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             giveup_r, giveup_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [31:0]      seqv_r, seqv_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [TMO_W-1:0] init_tmo_r;
  logic [TMO_W-1:0] max_tmo_r;
  logic [RTY_W-1:0] limit_r;
  result_t          res_r, res_nxt;

  logic [IDX_W-1:0] tail;
  logic [LEN_W-1:0] plen_sat;
  logic [LEN_W:0]   seq_span;
  logic             last_k;
  logic             at_limit;
  logic [TMO_W-1:0] tmo_backoff;

  assign busy   = (state_r != S_IDLE);
  assign result = res_r;

  assign tail     = ring_add(head_r, count_r);
  assign plen_sat = (32'(in_payload_len) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                             : in_payload_len;
  assign seq_span = (LEN_W+1)'(plen_sat) + (LEN_W+1)'(flag_extra(in_seg_flags));
  assign last_k   = ((k_r + CNT_W'(1)) == count_r);
  assign at_limit = (ring_rdata.retries >= limit_r);
  assign tmo_backoff = (ring_rdata.tmo < (max_tmo_r >> 1)) ? (ring_rdata.tmo << 1)
                                                           : max_tmo_r;

  assign ring_raddr = (state_r == S_ACK_RD) ? head_r : ring_add(head_r, k_r);

  always_comb begin
    alu_req.op  = ALU_AHEAD;
    alu_req.a   = seqv_r;
    alu_req.b   = mark_r;
    alu_req.lim = ring_rdata.tmo;
    case (state_r)
      S_ACK_EV: begin
        alu_req.op = ALU_COVER;
        alu_req.a  = mark_r;
        alu_req.b  = ring_rdata.end_seq;
      end
      S_P1_EV, S_P2_EV: begin
        alu_req.op = ALU_EXPIRE;
        alu_req.a  = now_r;
        alu_req.b  = ring_rdata.sent;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    mark_nxt   = mark_r;
    k_nxt      = k_r;
    giveup_nxt = giveup_r;
    cur_nxt    = cur_r;
    seqv_nxt   = seqv_r;
    now_nxt    = now_r;
    res_nxt    = '0;

    ring_wr         = '0;
    ring_wr.addr    = cur_r;
    ring_wr.data    = ring_rdata;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          seqv_nxt = in_seq_value;
          now_nxt  = in_now_ms;
          k_nxt    = '0;
          case (op_t'(in_op))
            OP_PUSH: begin
              res_nxt.valid = 1'b1;
              res_nxt.last  = 1'b1;
              if (count_r == CNT_W'(RING_DEPTH)) begin
                res_nxt.kind      = KIND_RING_FULL;
                res_nxt.occupancy = count_r;
              end else begin
                ring_wr.we           = 1'b1;
                ring_wr.addr         = tail;
                ring_wr.data.seq     = in_seq_value;
                ring_wr.data.end_seq = in_seq_value + 32'(seq_span);
                ring_wr.data.len     = plen_sat;
                ring_wr.data.flags   = in_seg_flags;
                ring_wr.data.sent    = in_now_ms;
                ring_wr.data.tmo     = init_tmo_r;
                ring_wr.data.retries = '0;
                count_nxt            = count_r + CNT_W'(1);
                res_nxt.kind         = KIND_PUSHED;
                res_nxt.slot         = tail;
                res_nxt.occupancy    = count_r + CNT_W'(1);
              end
            end
            OP_ACK: begin
              state_nxt = S_ACK_CMP;
            end
            OP_TICK: begin
              giveup_nxt = 1'b0;
              state_nxt  = (count_r == '0) ? S_TDONE : S_P1_RD;
            end
            default: begin
              head_nxt          = '0;
              count_nxt         = '0;
              mark_nxt          = in_seq_value;
              res_nxt.valid     = 1'b1;
              res_nxt.kind      = KIND_DONE;
              res_nxt.occupancy = '0;
              res_nxt.last      = 1'b1;
            end
          endcase
        end
      end

      S_ACK_CMP: begin
        if (alu_hit && (count_r != '0)) begin
          mark_nxt  = seqv_r;
          state_nxt = S_ACK_RD;
        end else begin
          if (alu_hit) begin
            mark_nxt = seqv_r;
          end
          res_nxt.valid     = 1'b1;
          res_nxt.kind      = KIND_DONE;
          res_nxt.occupancy = count_r;
          res_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      S_ACK_RD: begin
        cur_nxt   = ring_raddr;
        state_nxt = S_ACK_EV;
      end

      S_ACK_EV: begin
        // The front descriptor is freed once the mark reaches its end sequence.
        if (alu_hit) begin
          head_nxt  = ring_add(cur_r, CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
        if (alu_hit && (count_r != CNT_W'(1))) begin
          state_nxt = S_ACK_RD;
        end else begin
          res_nxt.valid     = 1'b1;
          res_nxt.kind      = KIND_DONE;
          res_nxt.occupancy = alu_hit ? (count_r - CNT_W'(1)) : count_r;
          res_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      S_P1_RD: begin
        cur_nxt   = ring_raddr;
        state_nxt = S_P1_EV;
      end

      S_P1_EV: begin
        // The first pass only learns whether this tick ends in a give-up, since
        // every retransmit result must already carry the final ring occupancy.
        if (alu_hit && at_limit) begin
          giveup_nxt = 1'b1;
          k_nxt      = '0;
          state_nxt  = S_P2_RD;
        end else if (last_k) begin
          k_nxt     = '0;
          state_nxt = S_P2_RD;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_P1_RD;
        end
      end

      S_P2_RD: begin
        cur_nxt   = ring_raddr;
        state_nxt = S_P2_EV;
      end

      S_P2_EV: begin
        if (alu_hit && at_limit) begin
          head_nxt          = '0;
          count_nxt         = '0;
          res_nxt.valid     = 1'b1;
          res_nxt.kind      = KIND_GAVE_UP;
          res_nxt.occupancy = '0;
          res_nxt.last      = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          if (alu_hit) begin
            ring_wr.we           = 1'b1;
            ring_wr.data.sent    = now_r;
            ring_wr.data.tmo     = tmo_backoff;
            ring_wr.data.retries = ring_rdata.retries + RTY_W'(1);
            res_nxt.valid        = 1'b1;
            res_nxt.kind         = KIND_RETRANSMIT;
            res_nxt.slot         = cur_r;
            res_nxt.seq          = ring_rdata.seq;
            res_nxt.flags        = ring_rdata.flags;
            res_nxt.len          = ring_rdata.len;
            res_nxt.retries      = ring_rdata.retries + RTY_W'(1);
            res_nxt.occupancy    = giveup_r ? '0 : count_r;
          end
          if (last_k) begin
            state_nxt = S_TDONE;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = S_P2_RD;
          end
        end
      end

      S_TDONE: begin
        res_nxt.valid     = 1'b1;
        res_nxt.kind      = KIND_TICK_DONE;
        res_nxt.occupancy = count_r;
        res_nxt.last      = 1'b1;
        state_nxt         = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      mark_r     <= '0;
      k_r        <= '0;
      giveup_r   <= 1'b0;
      res_r      <= '0;
      init_tmo_r <= INIT_TMO_RST;
      max_tmo_r  <= MAX_TMO_RST;
      limit_r    <= RETRY_LIM_RST;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      mark_r   <= mark_nxt;
      k_r      <= k_nxt;
      giveup_r <= giveup_nxt;
      res_r    <= res_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_TMO:  init_tmo_r <= cfg_data;
          CFG_MAX_TMO:   max_tmo_r  <= cfg_data;
          CFG_RETRY_LIM: limit_r    <= cfg_data[RTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    seqv_r <= seqv_nxt;
    now_r  <= now_nxt;
  end

endmodule

>>> rtl/tcp_retransmit_tracker_core.sv
// Top level of the TCP retransmit tracker with exponential backoff.
// Depends on rtt_pkg and instantiates rtt_ctrl, rtt_ring and rtt_alu.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+-------------------------------------------
//   request  | start / busy            | in_op, in_seq_value, in_payload_len,
//            |                         | in_seg_flags, in_now_ms
//   result   | out_valid (one cycle)   | out_kind, out_slot, out_seq_out, out_flags_out,
//            |                         | out_len_out, out_retry_count, out_occupancy,
//            |                         | out_last_of_run
//   config   | cfg_we                  | cfg_index, cfg_data
//
// Push and clear finish in the accept cycle; the result is registered and shows in the next cycle.
// An ack compares its value with the mark, then reads and tests descriptors in order: each
// freed one and the one still outstanding that stops the walk; a tick walks the held
// descriptors twice (each walk ends early on a give-up), set by the single read port of
// the descriptor memory and the shared compare unit. Results cannot be held off, and a
// new request is taken only while busy is low. Reset (rst_n low, synchronous) empties the
// ring, zeroes the mark and restores the register defaults; no clearing pass.
module tcp_retransmit_tracker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_seq_value,
  input  logic [rtt_pkg::LEN_W-1:0]    in_payload_len,
  input  logic [7:0]                   in_seg_flags,
  input  logic [31:0]                  in_now_ms,
  output logic                         out_valid,
  output logic [2:0]                   out_kind,
  output logic [rtt_pkg::IDX_W-1:0]    out_slot,
  output logic [31:0]                  out_seq_out,
  output logic [7:0]                   out_flags_out,
  output logic [rtt_pkg::LEN_W-1:0]    out_len_out,
  output logic [rtt_pkg::RTY_W-1:0]    out_retry_count,
  output logic [rtt_pkg::CNT_W-1:0]    out_occupancy,
  output logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  import rtt_pkg::*;

  ring_wr_t         ring_wr;
  logic [IDX_W-1:0] ring_raddr;
  entry_t           ring_rdata;
  alu_req_t         alu_req;
  logic             alu_hit;
  result_t          result;

  rtt_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_seq_value   (in_seq_value),
    .in_payload_len (in_payload_len),
    .in_seg_flags   (in_seg_flags),
    .in_now_ms      (in_now_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ring_wr        (ring_wr),
    .ring_raddr     (ring_raddr),
    .ring_rdata     (ring_rdata),
    .alu_req        (alu_req),
    .alu_hit        (alu_hit),
    .result         (result)
  );

  rtt_ring u_ring (
    .clk   (clk),
    .wr    (ring_wr),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  rtt_alu u_alu (
    .req (alu_req),
    .hit (alu_hit)
  );

  assign out_valid       = result.valid;
  assign out_kind        = result.kind;
  assign out_slot        = result.slot;
  assign out_seq_out     = result.seq;
  assign out_flags_out   = result.flags;
  assign out_len_out     = result.len;
  assign out_retry_count = result.retries;
  assign out_occupancy   = result.occupancy;
  assign out_last_of_run = result.last;

endmodule

>>> tb/sv/tcp_retransmit_tracker_checker.sv
// Checker for the TCP retransmit tracker: watches the request, result and register ports,
// predicts every result from its own copy of the ring, and compares them field by field.
// Depends on rtt_pkg for widths, the op and kind codes, and the register indexes.
module tcp_retransmit_tracker_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   in_op,
  input  logic [31:0]                  in_seq_value,
  input  logic [rtt_pkg::LEN_W-1:0]    in_payload_len,
  input  logic [7:0]                   in_seg_flags,
  input  logic [31:0]                  in_now_ms,
  input  logic                         out_valid,
  input  logic [2:0]                   out_kind,
  input  logic [rtt_pkg::IDX_W-1:0]    out_slot,
  input  logic [31:0]                  out_seq_out,
  input  logic [7:0]                   out_flags_out,
  input  logic [rtt_pkg::LEN_W-1:0]    out_len_out,
  input  logic [rtt_pkg::RTY_W-1:0]    out_retry_count,
  input  logic [rtt_pkg::CNT_W-1:0]    out_occupancy,
  input  logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import rtt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] slot;
    logic [31:0]      seq;
    logic [7:0]       flags;
    logic [LEN_W-1:0] len;
    logic [RTY_W-1:0] tries;
    logic [CNT_W-1:0] occupancy;
    logic             last;
  } segment_event_t;

  // Descriptor ring as the block should hold it.
  logic [31:0]      seg_start     [RING_DEPTH];
  logic [LEN_W-1:0] seg_span      [RING_DEPTH];
  logic [7:0]       seg_flag_byte [RING_DEPTH];
  logic [31:0]      seg_sent      [RING_DEPTH];
  logic [TMO_W-1:0] seg_rto       [RING_DEPTH];
  logic [RTY_W-1:0] seg_tries     [RING_DEPTH];
  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] held;
  logic [31:0]      snd_una;

  logic [TMO_W-1:0] rto_initial;
  logic [TMO_W-1:0] rto_cap;
  logic [RTY_W-1:0] max_tries;

  segment_event_t   expected_events[$];
  segment_event_t   want;

  function automatic logic [1:0] flag_cost(input logic [7:0] flags);
    return {1'b0, flags[FLAG_SYN_BIT]} + {1'b0, flags[FLAG_FIN_BIT]};
  endfunction

  function automatic segment_event_t mk_event(input kind_t kind, input logic [IDX_W-1:0] slot,
                                              input logic [31:0] seq, input logic [7:0] flags,
                                              input logic [LEN_W-1:0] len,
                                              input logic [RTY_W-1:0] tries);
    segment_event_t ev;
    ev.kind      = kind;
    ev.slot      = slot;
    ev.seq       = seq;
    ev.flags     = flags;
    ev.len       = len;
    ev.tries     = tries;
    ev.occupancy = '0;
    ev.last      = 1'b0;
    return ev;
  endfunction

  task automatic predict_request(input logic [1:0] op, input logic [31:0] seqv,
                                 input logic [LEN_W-1:0] plen, input logic [7:0] flags,
                                 input logic [31:0] now);
    segment_event_t   made[$];
    logic [IDX_W-1:0] idx;
    logic [LEN_W-1:0] body;
    logic [31:0]      diff;
    logic [31:0]      elapsed;
    bit               gave_up;
    int               k;
    gave_up = 1'b0;
    case (op)
      OP_PUSH: begin
        if (held >= CNT_W'(RING_DEPTH)) begin
          made.push_back(mk_event(KIND_RING_FULL, '0, '0, '0, '0, '0));
        end else begin
          idx  = IDX_W'((int'(oldest) + int'(held)) % RING_DEPTH);
          body = (plen > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : plen;
          seg_start[idx]     = seqv;
          seg_span[idx]      = body + LEN_W'(flag_cost(flags));
          seg_flag_byte[idx] = flags;
          seg_sent[idx]      = now;
          seg_rto[idx]       = rto_initial;
          seg_tries[idx]     = '0;
          held = held + 1'b1;
          made.push_back(mk_event(KIND_PUSHED, idx, '0, '0, '0, '0));
        end
      end
      OP_ACK: begin
        // Only an ack strictly ahead of the mark, in wrap-safe terms, moves anything.
        diff = seqv - snd_una;
        if (diff != 32'd0 && !diff[31]) begin
          snd_una = seqv;
          while (held > 0) begin
            diff = snd_una - (seg_start[oldest] + 32'(seg_span[oldest]));
            if (diff[31]) break;
            oldest = IDX_W'((int'(oldest) + 1) % RING_DEPTH);
            held   = held - 1'b1;
          end
        end
        made.push_back(mk_event(KIND_DONE, '0, '0, '0, '0, '0));
      end
      OP_TICK: begin
        for (k = 0; k < int'(held); k++) begin
          idx     = IDX_W'((int'(oldest) + k) % RING_DEPTH);
          elapsed = now - seg_sent[idx];
          if (elapsed < 32'(seg_rto[idx])) continue;
          if (seg_tries[idx] >= max_tries) begin
            held    = '0;
            oldest  = '0;
            gave_up = 1'b1;
            break;
          end
          seg_sent[idx]  = now;
          seg_tries[idx] = seg_tries[idx] + 1'b1;
          if (32'(seg_rto[idx]) < 32'(rto_cap) / 2) begin
            seg_rto[idx] = seg_rto[idx] << 1;
          end else begin
            seg_rto[idx] = rto_cap;
          end
          made.push_back(mk_event(KIND_RETRANSMIT, idx, seg_start[idx], seg_flag_byte[idx],
                                  seg_span[idx] - LEN_W'(flag_cost(seg_flag_byte[idx])),
                                  seg_tries[idx]));
        end
        made.push_back(mk_event(gave_up ? KIND_GAVE_UP : KIND_TICK_DONE, '0, '0, '0, '0, '0));
      end
      default: begin
        held    = '0;
        oldest  = '0;
        snd_una = seqv;
        made.push_back(mk_event(KIND_DONE, '0, '0, '0, '0, '0));
      end
    endcase
    // Every result of a request reports the ring occupancy after the whole request.
    foreach (made[i]) begin
      made[i].occupancy = held;
      made[i].last      = (i == made.size() - 1);
      expected_events.push_back(made[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held        = '0;
      oldest      = '0;
      snd_una     = '0;
      rto_initial = INIT_TMO_RST;
      rto_cap     = MAX_TMO_RST;
      max_tries   = RETRY_LIM_RST;
      fail_count  = 0;
      expected_events.delete();
    end else begin
      if (out_valid) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual kind %0h",
                   $time, out_kind);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("seq_out", want.seq, out_seq_out);
          check_field("flags_out", 32'(want.flags), 32'(out_flags_out));
          check_field("len_out", 32'(want.len), 32'(out_len_out));
          check_field("retry_count", 32'(want.tries), 32'(out_retry_count));
          check_field("occupancy", 32'(want.occupancy), 32'(out_occupancy));
          check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_TMO:  rto_initial = cfg_data;
          CFG_MAX_TMO:   rto_cap     = cfg_data;
          CFG_RETRY_LIM: max_tries   = cfg_data[RTY_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_request(in_op, in_seq_value, in_payload_len, in_seg_flags, in_now_ms);
      end
    end
    pending = expected_events.size();
  end

endmodule

>>> tb/sv/tb_tcp_retransmit_tracker_core.sv
// Top of the retransmit tracker testbench: clock, reset, register writes and requests.
// Depends on rtt_pkg, tcp_retransmit_tracker_core and tcp_retransmit_tracker_checker.
module tb_tcp_retransmit_tracker_core;
  import rtt_pkg::*;

  localparam logic [1:0] CFG_NO_SUCH_REG = 2'd3;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int DRAIN_CYCLES    = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [31:0]       in_seq_value;
  logic [LEN_W-1:0]  in_payload_len;
  logic [7:0]        in_seg_flags;
  logic [31:0]       in_now_ms;
  logic              out_valid;
  logic [2:0]        out_kind;
  logic [IDX_W-1:0]  out_slot;
  logic [31:0]       out_seq_out;
  logic [7:0]        out_flags_out;
  logic [LEN_W-1:0]  out_len_out;
  logic [RTY_W-1:0]  out_retry_count;
  logic [CNT_W-1:0]  out_occupancy;
  logic              out_last_of_run;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;
  int                fail_count;
  int                pending;

  // Connection as the sender sees it: next sequence to send, last ack sent, clock.
  logic [31:0]       snd_nxt;
  logic [31:0]       snd_una;
  logic [31:0]       clock_ms;
  logic [15:0]       cur_init;
  logic [15:0]       cur_cap;
  int                idle_pct;

  int                phase_init  [RANDOM_PHASES] = '{4, 1, 65535, 10, 300, 7};
  int                phase_cap   [RANDOM_PHASES] = '{64, 1, 65535, 200, 100, 50};
  int                phase_tries [RANDOM_PHASES] = '{3, 15, 15, 5, 2, 0};
  int                phase_idle  [RANDOM_PHASES] = '{0, 77, 18, 0, 77, 18};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tcp_retransmit_tracker_core u_dut (.*);

  tcp_retransmit_tracker_checker u_check (.*);

  function automatic logic [31:0] seq_cost(input logic [LEN_W-1:0] len,
                                           input logic [7:0] flags);
    logic [31:0] body;
    body = (len > LEN_W'(MAX_PAYLOAD)) ? 32'(MAX_PAYLOAD) : 32'(len);
    return body + 32'(flags[FLAG_SYN_BIT]) + 32'(flags[FLAG_FIN_BIT]);
  endfunction

  task automatic send_request(input op_t op, input logic [31:0] seqv,
                              input logic [LEN_W-1:0] plen, input logic [7:0] flags,
                              input logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_seq_value   <= seqv;
    in_payload_len <= plen;
    in_seg_flags   <= flags;
    in_now_ms      <= now;
    // busy only moves at the rising edge, so its value at the falling edge decides.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_seg(input logic [LEN_W-1:0] len, input logic [7:0] flags,
                          input logic [31:0] now);
    send_request(OP_PUSH, snd_nxt, len, flags, now);
    snd_nxt = snd_nxt + seq_cost(len, flags);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timers(input logic [15:0] init, input logic [15:0] cap,
                            input logic [15:0] tries);
    settle();
    write_reg(CFG_INIT_TMO, init);
    write_reg(CFG_MAX_TMO, cap);
    write_reg(CFG_RETRY_LIM, tries);
    cur_init = init;
    cur_cap  = cap;
  endtask

  task automatic random_request();
    int          pick;
    logic [31:0] span;
    logic [31:0] val;
    logic [31:0] step_max;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 15) begin
      // Noise: any op with fully random fields.
      send_request(op_t'($urandom_range(3)), $urandom, LEN_W'($urandom_range(2047)),
                   8'($urandom_range(255)), $urandom);
    end else if (pick < 38) begin
      push_seg(($urandom_range(7) == 0) ? LEN_W'($urandom_range(2047))
                                        : LEN_W'($urandom_range(100)),
               8'($urandom_range(255)), clock_ms);
    end else if (pick < 60) begin
      span = snd_nxt - snd_una;
      if ($urandom_range(9) == 0) begin
        val = snd_una - $urandom_range(1000);
      end else if (span == 0 || $urandom_range(2) == 0) begin
        val = snd_nxt;
      end else begin
        val = snd_una + ($urandom % span) + 1;
      end
      send_request(OP_ACK, val, '0, '0, '0);
      snd_una = val;
    end else if (pick < 93) begin
      step_max = (cur_init > cur_cap) ? 32'(cur_init) : 32'(cur_cap);
      clock_ms = clock_ms + $urandom_range(2 * step_max);
      send_request(OP_TICK, '0, '0, '0, clock_ms);
    end else begin
      send_request(OP_CLEAR, snd_nxt, '0, '0, '0);
      snd_una = snd_nxt;
    end
  endtask

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    start          = 1'b0;
    in_op          = OP_PUSH;
    in_seq_value   = '0;
    in_payload_len = '0;
    in_seg_flags   = '0;
    in_now_ms      = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_INIT_TMO;
    cfg_data       = '0;
    rst_n          = 1'b0;
    idle_pct       = 0;
    snd_nxt        = 32'hFFFF_FFF0;
    snd_una        = '0;
    clock_ms       = '0;
    cur_init       = INIT_TMO_RST;
    cur_cap        = MAX_TMO_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring, then an ack equal to the mark, which must change nothing.
    send_request(OP_TICK, '0, '0, '0, '0);
    send_request(OP_ACK, '0, '0, '0, '0);
    // Fill the ring across the sequence wrap with odd lengths and flag mixes.
    push_seg(11'd2047, 8'hFF, '0);
    push_seg(11'd0, 8'h00, '0);
    push_seg(11'd1400, 8'h01, '0);
    push_seg(11'd1401, 8'h02, '0);
    push_seg(11'd5, 8'h03, '0);
    push_seg(11'd1024, 8'hFC, '0);
    push_seg(11'd1, 8'h80, '0);
    push_seg(11'd700, 8'h55, '0);
    push_seg(11'd3, 8'h00, '0);
    // One short of the timeout, then every descriptor expires at once.
    send_request(OP_TICK, '0, '0, '0, 32'd999);
    send_request(OP_TICK, '0, '0, '0, 32'd1000);
    // Covers the first segment and the empty one right behind it.
    send_request(OP_ACK, 32'h0000_056A, '0, '0, '0);
    send_request(OP_ACK, 32'h0000_056A - 32'd100, '0, '0, '0);
    send_request(OP_ACK, 32'h8000_056A, '0, '0, '0);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, '0, '0, '0);
    snd_nxt = 32'hFFFF_FFFF;
    snd_una = snd_nxt;

    // Initial timeout above the cap, with time wrapping between push and tick.
    set_timers(16'd65535, 16'd1, 16'd1);
    write_reg(CFG_NO_SUCH_REG, 16'h0000);
    push_seg(11'd100, 8'h00, 32'hFFFF_FFFF);
    send_request(OP_TICK, '0, '0, '0, 32'd65534);
    send_request(OP_TICK, '0, '0, '0, 32'd65535);

    // A newer segment gives up after an older one was already retransmitted.
    set_timers(16'd1000, 16'd65535, 16'd1);
    push_seg(11'd10, 8'h00, '0);
    set_timers(16'd5, 16'd65535, 16'd1);
    push_seg(11'd10, 8'h00, '0);
    send_request(OP_TICK, '0, '0, '0, 32'd5);
    send_request(OP_TICK, '0, '0, '0, 32'd1000);

    // With no retries allowed the first expiry gives up.
    set_timers(16'd5, 16'd65535, 16'd0);
    push_seg(11'd10, 8'h00, '0);
    send_request(OP_TICK, '0, '0, '0, 32'd5);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_timers(16'(phase_init[phase]), 16'(phase_cap[phase]), 16'(phase_tries[phase]));
      idle_pct = phase_idle[phase];
      clock_ms = $urandom;
      snd_nxt  = $urandom;
      snd_una  = snd_nxt;
      send_request(OP_CLEAR, snd_nxt, '0, '0, '0);
      repeat (ITEMS_PER_PHASE - 1) random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
